### design/ucrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_pkg: shared types and constants of the control request responder
// Request and result payload types, codes and the string character table.
// ----------------------------------------------------------------------------
package ucrr_pkg;

	localparam int EP_MAX_PACKET = 64;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] setup_value;
		logic [15:0] setup_index;
		logic [15:0] setup_length;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] resp_byte;
		logic       last;
		logic [1:0] usb_event;
		logic       is_configured;
		logic       suspend_flag;
	} rsp_t;

	localparam logic [1:0] OP_SETUP   = 2'd0;
	localparam logic [1:0] OP_RESET   = 2'd1;
	localparam logic [1:0] OP_SUSPEND = 2'd2;
	localparam logic [1:0] OP_RESUME  = 2'd3;

	localparam logic [2:0] K_ACK   = 3'd0;
	localparam logic [2:0] K_STALL = 3'd1;
	localparam logic [2:0] K_DATA  = 3'd2;
	localparam logic [2:0] K_ZLP   = 3'd3;
	localparam logic [2:0] K_NONE  = 3'd4;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_CONN = 2'd1;
	localparam logic [1:0] EV_DISC = 2'd2;

	localparam logic [2:0] REG_VID  = 3'd0;
	localparam logic [2:0] REG_PID  = 3'd1;
	localparam logic [2:0] REG_REL  = 3'd2;
	localparam logic [2:0] REG_SELF = 3'd3;
	localparam logic [2:0] REG_WAKE = 3'd4;
	localparam logic [2:0] REG_MAXP = 3'd5;

	localparam logic [7:0] RQ_GET_STATUS = 8'h00;
	localparam logic [7:0] RQ_CLR_FEAT   = 8'h01;
	localparam logic [7:0] RQ_SET_FEAT   = 8'h03;
	localparam logic [7:0] RQ_SET_ADDR   = 8'h05;
	localparam logic [7:0] RQ_GET_DESC   = 8'h06;
	localparam logic [7:0] RQ_GET_CFG    = 8'h08;
	localparam logic [7:0] RQ_SET_CFG    = 8'h09;
	localparam logic [7:0] RQ_CLS_A      = 8'h0A;
	localparam logic [7:0] RQ_CLS_B      = 8'h0B;

	// Source selectors of the byte generator.
	localparam logic [2:0] SRC_DEV    = 3'd0;
	localparam logic [2:0] SRC_CFG    = 3'd1;
	localparam logic [2:0] SRC_LANG   = 3'd2;
	localparam logic [2:0] SRC_STR    = 3'd3;
	localparam logic [2:0] SRC_STATUS = 3'd4;
	localparam logic [2:0] SRC_CONF   = 3'd5;

	// Characters of the three strings, flat: maker 0..7, product 8..18, serial 19..30.
	function automatic logic [7:0] str_char(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = 8'h41;  5'd1: c = 8'h72;  5'd2: c = 8'h72;  5'd3: c = 8'h69;
			5'd4: c = 8'h62;  5'd5: c = 8'h61;  5'd6: c = 8'h64;  5'd7: c = 8'h61;
			5'd8: c = 8'h47;  5'd9: c = 8'h50;  5'd10: c = 8'h53; 5'd11: c = 8'h20;
			5'd12: c = 8'h54; 5'd13: c = 8'h72; 5'd14: c = 8'h61; 5'd15: c = 8'h63;
			5'd16: c = 8'h6B; 5'd17: c = 8'h65; 5'd18: c = 8'h72;
			5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27,
			5'd28: c = 8'h30;
			5'd29: c = 8'h31; 5'd30: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/ucrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_req_if / ucrr_rsp_if: valid-ready channels
// Request and result channels of the control request responder.
// ----------------------------------------------------------------------------
interface ucrr_req_if;
	logic              valid;
	logic              ready;
	ucrr_pkg::req_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ucrr_rsp_if;
	logic              valid;
	logic              ready;
	ucrr_pkg::rsp_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/ucrr_desc_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_desc_gen: reply byte generator
// Gives one byte of the selected descriptor or status reply at an offset.
// ----------------------------------------------------------------------------
module ucrr_desc_gen (
	input  logic [2:0]  src,
	input  logic [1:0]  str_sel,
	input  logic [4:0]  base,
	input  logic [4:0]  pos,
	input  logic [7:0]  status_lo,
	input  logic [15:0] vendor_id,
	input  logic [15:0] product_id,
	input  logic [15:0] device_release,
	input  logic        self_powered,
	input  logic        wakeup_capable,
	input  logic [7:0]  max_power,
	output logic [7:0]  data
);
	import ucrr_pkg::*;

	localparam logic [7:0] MP = 8'(EP_MAX_PACKET);

	logic [4:0] ofs;
	logic [4:0] ch;
	logic [4:0] ch_base;
	logic [7:0] slen;

	always_comb begin
		ofs = base + pos;
		case (str_sel)
			2'd1: begin ch_base = 5'd0; slen = 8'd18; end
			2'd2: begin ch_base = 5'd8; slen = 8'd24; end
			default: begin ch_base = 5'd19; slen = 8'd26; end
		endcase
		ch = ch_base + 5'(pos[4:1] - 4'd1);
		data = 8'h00;
		case (src)
			SRC_DEV: begin
				case (pos)
					5'd0: data = 8'h12; 5'd1: data = 8'h01; 5'd3: data = 8'h02;
					5'd7: data = MP;
					5'd8: data = vendor_id[7:0];       5'd9: data = vendor_id[15:8];
					5'd10: data = product_id[7:0];     5'd11: data = product_id[15:8];
					5'd12: data = device_release[7:0]; 5'd13: data = device_release[15:8];
					5'd14: data = 8'h01; 5'd15: data = 8'h02; 5'd16: data = 8'h03;
					5'd17: data = 8'h01;
					default: data = 8'h00;
				endcase
			end
			SRC_CFG: begin
				case (ofs)
					5'd0: data = 8'h09; 5'd1: data = 8'h02; 5'd2: data = 8'd32;
					5'd4: data = 8'h01; 5'd5: data = 8'h01;
					5'd7: data = {1'b1, self_powered, wakeup_capable, 5'd0};
					5'd8: data = max_power;
					5'd9: data = 8'h09; 5'd10: data = 8'h04; 5'd13: data = 8'h02;
					5'd14, 5'd15, 5'd16: data = 8'hFF;
					5'd18: data = 8'h07; 5'd19: data = 8'h05; 5'd20: data = 8'h01;
					5'd21: data = 8'h02; 5'd22: data = MP;
					5'd25: data = 8'h07; 5'd26: data = 8'h05; 5'd27: data = 8'h81;
					5'd28: data = 8'h02; 5'd29: data = MP;
					default: data = 8'h00;
				endcase
			end
			SRC_LANG: begin
				case (pos)
					5'd0: data = 8'h04; 5'd1: data = 8'h03; 5'd2: data = 8'h09;
					5'd3: data = 8'h08;
					default: data = 8'h00;
				endcase
			end
			SRC_STR: begin
				if (pos == 5'd0) begin
					data = slen;
				end else if (pos == 5'd1) begin
					data = 8'h03;
				end else if (!pos[0]) begin
					data = str_char(ch);
				end
			end
			SRC_STATUS, SRC_CONF: data = (pos == 5'd0) ? status_lo : 8'h00;
			default: data = 8'h00;
		endcase
	end
endmodule

### design/usb_control_request_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_request_responder: endpoint-0 standard request handler
// Decodes setup requests and bus events, keeps device state and streams
// replies one result per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Carries
// req       in   valid/ready   setup packet or bus event
// rsp       out  valid/ready   ack/stall/data byte/zero-length/no handshake
// cfg       in   write enable  register index and data
//
// A request is taken only when the block is idle. It reads the state word
// from a one-entry synchronous memory, decodes in the next cycle, then
// emits one result per cycle unless stalled: at most 32 results, for the
// 32-byte configuration descriptor. A stalled result holds in the output
// register. After reset the state word is cleared in the CLEAR state.
// ----------------------------------------------------------------------------
module usb_control_request_responder (
	input  logic        clk,
	input  logic        arst_n,
	ucrr_req_if.sink    req,
	ucrr_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ucrr_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DEC   = 3'd3;
	localparam logic [2:0] ST_SEND  = 3'd4;

	// State word: {suspend, halt_in, halt_out, remote_wake, configured}.
	logic [4:0] mem [1];
	logic [4:0] rd_s1;
	logic [4:0] wr_data;
	logic       wr_en;

	logic [2:0]  state_q;
	req_t        req_q;
	logic [15:0] vendor_id_q, product_id_q, device_release_q;
	logic        self_powered_q, wakeup_capable_q;
	logic [7:0]  max_power_q;

	// Reply stream.
	logic [2:0]  src_q;
	logic [1:0]  str_sel_q;
	logic [4:0]  base_q;
	logic [7:0]  status_q;
	logic [4:0]  pos_q;
	logic [5:0]  cnt_q;
	logic [2:0]  kind_q;
	logic        multi_q;
	logic [1:0]  ev_q;
	logic        conf_q, susp_q;

	logic        out_valid_q;
	rsp_t        out_q;
	logic [7:0]  gen_byte;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[0] <= wr_data;
		rd_s1 <= mem[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_id_q      <= 16'h1915;
			product_id_q     <= 16'h0100;
			device_release_q <= 16'h0101;
			self_powered_q   <= 1'b1;
			wakeup_capable_q <= 1'b1;
			max_power_q      <= 8'h32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VID:  vendor_id_q      <= cfg_data;
				REG_PID:  product_id_q     <= cfg_data;
				REG_REL:  device_release_q <= cfg_data;
				REG_SELF: self_powered_q   <= cfg_data[0];
				REG_WAKE: wakeup_capable_q <= cfg_data[0];
				REG_MAXP: max_power_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ucrr_desc_gen u_gen (
		.src(src_q), .str_sel(str_sel_q), .base(base_q), .pos(pos_q),
		.status_lo(status_q), .vendor_id(vendor_id_q), .product_id(product_id_q),
		.device_release(device_release_q), .self_powered(self_powered_q),
		.wakeup_capable(wakeup_capable_q), .max_power(max_power_q), .data(gen_byte)
	);

	// Decode: new state word and reply description from the request and old state.
	logic [4:0]  nxt;
	logic [2:0]  d_kind;
	logic        d_multi;
	logic [5:0]  d_len;
	logic [2:0]  d_src;
	logic [1:0]  d_str;
	logic [4:0]  d_base;
	logic [7:0]  d_stat;
	logic [1:0]  d_ev;
	logic [5:0]  d_cnt;
	logic        cf, rw, ho, hi;
	logic [7:0]  dt, ix, lo;

	always_comb begin
		{hi, ho, rw, cf} = rd_s1[3:0];
		nxt = rd_s1;
		d_kind = K_STALL; d_multi = 1'b0; d_len = 6'd0; d_src = SRC_DEV;
		d_str = 2'd1; d_base = 5'd0; d_stat = 8'd0; d_ev = EV_NONE;
		dt = req_q.setup_value[15:8];
		ix = req_q.setup_value[7:0];
		lo = req_q.setup_index[7:0];
		case (req_q.op)
			OP_RESET, OP_SUSPEND: begin
				d_ev = cf ? EV_DISC : EV_NONE;
				nxt[0] = 1'b0;
				nxt[4] = (req_q.op == OP_SUSPEND);
				d_kind = K_NONE;
			end
			OP_RESUME: begin
				nxt[4] = 1'b0;
				d_kind = K_NONE;
			end
			default: begin
				case (req_q.request_code)
					RQ_GET_STATUS: begin
						d_src = SRC_STATUS;
						d_multi = 1'b1; d_len = 6'd2;
						if (req_q.request_type == 8'h80 && lo == 8'h00)
							d_stat = {6'd0, rw, self_powered_q};
						else if (req_q.request_type == 8'h81 && cf && lo == 8'h00)
							d_stat = 8'd0;
						else if (req_q.request_type == 8'h82 && lo == 8'h00)
							d_stat = 8'd0;
						else if (req_q.request_type == 8'h82 && cf && lo == 8'h01)
							d_stat = {7'd0, ho};
						else if (req_q.request_type == 8'h82 && cf && lo == 8'h81)
							d_stat = {7'd0, hi};
						else
							d_multi = 1'b0;
					end
					RQ_CLR_FEAT, RQ_SET_FEAT: begin
						if (req_q.request_type == 8'h02 && req_q.setup_value == 16'd0) begin
							if (req_q.setup_index == 16'h0001) begin
								nxt[2] = req_q.request_code[1];
								d_kind = K_ACK;
							end else if (req_q.setup_index == 16'h0081) begin
								nxt[3] = req_q.request_code[1];
								d_kind = K_ACK;
							end
						end else if (req_q.request_type == 8'h00 && wakeup_capable_q
								&& req_q.setup_value == 16'd1) begin
							nxt[1] = req_q.request_code[1];
							d_kind = K_ACK;
						end
					end
					RQ_SET_ADDR: d_kind = K_NONE;
					RQ_GET_DESC: begin
						if (req_q.request_type == 8'h80) begin
							d_multi = 1'b1;
							case (dt)
								8'd1: begin d_src = SRC_DEV; d_len = 6'd18; end
								8'd2: begin d_src = SRC_CFG; d_len = 6'd32; end
								8'd3: begin
									case (ix)
										8'd0: begin d_src = SRC_LANG; d_len = 6'd4; end
										8'd1: begin d_src = SRC_STR; d_str = 2'd1; d_len = 6'd18; end
										8'd2: begin d_src = SRC_STR; d_str = 2'd2; d_len = 6'd24; end
										8'd3: begin d_src = SRC_STR; d_str = 2'd3; d_len = 6'd26; end
										default: d_multi = 1'b0;
									endcase
								end
								8'd4: begin
									d_src = SRC_CFG; d_base = 5'd9; d_len = 6'd9;
									if (ix != 8'd0) d_multi = 1'b0;
								end
								8'd5: begin
									d_src = SRC_CFG; d_len = 6'd7;
									if (ix == 8'd1) d_base = 5'd25;
									else if (ix == 8'd2) d_base = 5'd18;
									else d_multi = 1'b0;
								end
								default: d_multi = 1'b0;
							endcase
						end
					end
					RQ_GET_CFG: begin
						d_src = SRC_CONF; d_multi = 1'b1; d_len = 6'd1;
						d_stat = {7'd0, cf};
					end
					RQ_SET_CFG: begin
						if (req_q.request_type == 8'h00 && req_q.setup_index == 16'd0
								&& req_q.setup_length == 16'd0 && req_q.setup_value <= 16'd1) begin
							d_kind = K_ACK;
							if (req_q.setup_value[0]) begin
								nxt[3:2] = 2'b00; nxt[0] = 1'b1; d_ev = EV_CONN;
							end else begin
								d_ev = cf ? EV_DISC : EV_NONE; nxt[0] = 1'b0;
							end
						end
					end
					RQ_CLS_A, RQ_CLS_B:
						d_kind = (req_q.request_type == 8'h21) ? K_ACK : K_STALL;
					default: d_kind = K_STALL;
				endcase
			end
		endcase
		// Truncate to wLength; a zero count is a zero-length reply.
		d_cnt = (req_q.setup_length < 16'(d_len)) ? req_q.setup_length[5:0] : d_len;
		if (d_multi && d_cnt == 6'd0) begin
			d_multi = 1'b0;
			d_kind = K_ZLP;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign wr_en = (state_q == ST_CLEAR) || (state_q == ST_DEC);
	assign wr_data = (state_q == ST_CLEAR) ? 5'd0 : nxt;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_q <= req.payload;
		if (state_q == ST_DEC) begin
			src_q <= d_src; str_sel_q <= d_str; base_q <= d_base; status_q <= d_stat;
			cnt_q <= d_cnt; kind_q <= d_kind; multi_q <= d_multi;
			ev_q <= d_ev; conf_q <= nxt[0]; susp_q <= nxt[4];
			pos_q <= 5'd0;
		end else if (state_q == ST_SEND && out_free && multi_q) begin
			pos_q <= pos_q + 5'd1;
		end
		if (state_q == ST_SEND && out_free) begin
			out_q.kind <= multi_q ? K_DATA : kind_q;
			out_q.resp_byte <= multi_q ? gen_byte : 8'd0;
			out_q.last <= !multi_q || (6'(pos_q) + 6'd1 == cnt_q);
			out_q.usb_event <= ev_q;
			out_q.is_configured <= conf_q;
			out_q.suspend_flag <= susp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken one leaves it.
			if (state_q == ST_SEND && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: state_q <= ST_IDLE;
				ST_IDLE: if (req.valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_DEC;
				ST_DEC: state_q <= ST_SEND;
				ST_SEND: begin
					if (out_free) begin
						if (!multi_q || 6'(pos_q) + 6'd1 == cnt_q)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/ucrr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_checker: port-level checks of the control request responder
// Watches the result channel for stable stalled results and legal codes, and the request channel for a busy block.
// ----------------------------------------------------------------------------
module ucrr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ucrr_pkg::rsp_t rsp_payload,
	input logic           req_valid,
	input logic           req_ready
);
	import ucrr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled result changed");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.kind != K_DATA |-> rsp_payload.resp_byte == 8'd0)
		else $error("byte on non-data result");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.kind != K_DATA |-> rsp_payload.last)
		else $error("non-data result not last");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.kind <= K_NONE && rsp_payload.usb_event != 2'd3)
		else $error("illegal result code");

	// A taken request keeps the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");
endmodule

bind usb_control_request_responder ucrr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload), .req_valid(req.valid), .req_ready(req.ready)
);
